FILE: hdl/uer_pkg.sv
// Shared constants for the ultrasonic echo ranger: phase codes, status codes, register map.
package uer_pkg;

  localparam int unsigned FractionBitsDefault = 4;
  localparam int unsigned PulseWidth          = 16;
  localparam int unsigned DistWidth           = 15;
  localparam int unsigned DistDivisor         = 58;
  localparam int unsigned DistMax             = 32767;

  // Measurement phases
  localparam logic [2:0] PhIdle     = 3'd0;
  localparam logic [2:0] PhWaitLow  = 3'd1;
  localparam logic [2:0] PhSettle   = 3'd2;
  localparam logic [2:0] PhTrig     = 3'd3;
  localparam logic [2:0] PhWaitRise = 3'd4;
  localparam logic [2:0] PhMeasure  = 3'd5;

  // Result status codes
  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StNoEcho = 2'd1;
  localparam logic [1:0] StStuck  = 2'd2;
  localparam logic [1:0] StRange  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] RegTimeout  = 3'd0;
  localparam logic [2:0] RegMinPulse = 3'd1;
  localparam logic [2:0] RegMaxPulse = 3'd2;
  localparam logic [2:0] RegTrigW    = 3'd3;
  localparam logic [2:0] RegSettle   = 3'd4;

  // Register reset values
  localparam logic [15:0] TimeoutRst  = 16'd30000;
  localparam logic [15:0] MinPulseRst = 16'd116;
  localparam logic [15:0] MaxPulseRst = 16'd23200;
  localparam logic [7:0]  TrigWRst    = 8'd10;
  localparam logic [7:0]  SettleRst   = 8'd2;

endpackage

FILE: hdl/uer_dist.sv
// Pulse length to distance: (pulse << FRACTION_BITS) / 58 by exact reciprocal, saturated.
module uer_dist #(
  parameter int unsigned FRACTION_BITS = uer_pkg::FractionBitsDefault
) (
  input  logic [uer_pkg::PulseWidth-1:0] pulse_i,
  output logic [uer_pkg::DistWidth-1:0]  dist_o
);

  localparam int unsigned XW = uer_pkg::PulseWidth + FRACTION_BITS;
  localparam int unsigned S  = XW + 6;
  localparam int unsigned QW = XW - 5;
  localparam int unsigned PW = 2 * XW + 1;
  // ceil(2^S / 58) gives an exact floor for every XW-bit dividend
  localparam logic [XW:0] RecipM =
    (XW + 1)'(((64'd1 << S) + 64'(uer_pkg::DistDivisor - 1)) / 64'(uer_pkg::DistDivisor));

  logic [XW-1:0] scaled;
  logic [PW-1:0] prod;
  logic [QW-1:0] quot;
  logic [31:0]   quot_ext;

  assign scaled   = XW'(pulse_i) << FRACTION_BITS;
  assign prod     = PW'(scaled) * PW'(RecipM);
  assign quot     = prod[S +: QW];
  assign quot_ext = 32'(quot);

  always_comb begin
    if (quot_ext > 32'(uer_pkg::DistMax)) begin
      dist_o = uer_pkg::DistWidth'(uer_pkg::DistMax);
    end else begin
      dist_o = quot_ext[uer_pkg::DistWidth-1:0];
    end
  end

endmodule

FILE: hdl/ultrasonic_echo_ranger_core.sv
// Ultrasonic echo ranger top level: per-tick phase sequencer, pulse history and result register.
//
// One input transaction per microsecond tick carries the sampled echo level and
// a start request; each one yields exactly one result transaction with the
// trigger drive, busy, done, status and distance for that tick.
// Configuration: cfg channel writes register cfg_index_i (0 timeout, 1 min pulse,
// 2 max pulse, 3 trigger width, 4 settle) with cfg_data_i; always ready, only
// to be used while idle. Unknown indexes are dropped.
// The result of a tick is registered and presented in the cycle after its transaction.
// Throughput: one tick per cycle while out_ready_i is high; the sequencer step, median of three and the
// reciprocal multiply for distance all fit between the state and result regs.
// When the receiver stalls, the held result keeps out_valid_o high and
// in_ready_o follows out_ready_i, so a new tick is taken in the cycle the
// pending result leaves.
// Reset: phase idle, timer and history cleared, registers to their defaults,
// no result pending.
module ultrasonic_echo_ranger_core #(
  parameter int unsigned FRACTION_BITS = uer_pkg::FractionBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        echo_level_i,
  input  logic        start_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        trig_level_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [1:0]  status_o,
  output logic [uer_pkg::DistWidth-1:0] distance_q4_o
);

  logic [15:0] timeout_q, min_pulse_q, max_pulse_q;
  logic [7:0]  trig_w_q, settle_q;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] timer_q, timer_d;
  logic [15:0] hist_q [3];
  logic [15:0] hist_d [3];
  logic [1:0]  fill_q, fill_d;
  logic [1:0]  slot_q, slot_d;

  logic        out_valid_q;
  logic        trig_q, busy_q, done_q;
  logic [1:0]  status_q;
  logic [uer_pkg::DistWidth-1:0] dist_q;

  logic        trig_c, busy_c, done_c, ok_c;
  logic [1:0]  status_c;
  logic [15:0] chosen_c;
  logic [uer_pkg::DistWidth-1:0] dist_c;
  logic        accept;

  function automatic logic [15:0] mid3(input logic [15:0] a, input logic [15:0] b,
                                       input logic [15:0] c);
    logic [15:0] lo, hi, m;
    lo = (a > b) ? b : a;
    hi = (a > b) ? a : b;
    m  = (hi > c) ? c : hi;
    mid3 = (lo > m) ? lo : m;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= uer_pkg::TimeoutRst;
      min_pulse_q <= uer_pkg::MinPulseRst;
      max_pulse_q <= uer_pkg::MaxPulseRst;
      trig_w_q    <= uer_pkg::TrigWRst;
      settle_q    <= uer_pkg::SettleRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        uer_pkg::RegTimeout:  timeout_q   <= cfg_data_i;
        uer_pkg::RegMinPulse: min_pulse_q <= cfg_data_i;
        uer_pkg::RegMaxPulse: max_pulse_q <= cfg_data_i;
        uer_pkg::RegTrigW:    trig_w_q    <= cfg_data_i[7:0];
        uer_pkg::RegSettle:   settle_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [1:0] slot;
    phase_d  = phase_q;
    timer_d  = timer_q;
    hist_d   = hist_q;
    fill_d   = fill_q;
    slot_d   = slot_q;
    trig_c   = 1'b0;
    busy_c   = 1'b1;
    done_c   = 1'b0;
    status_c = uer_pkg::StOk;
    ok_c     = 1'b0;
    chosen_c = timer_q;
    slot     = (slot_q > 2'd2) ? 2'd0 : slot_q;

    unique case (phase_q)
      uer_pkg::PhWaitLow: begin
        if (!echo_level_i) begin
          phase_d = (settle_q == 8'd0) ? uer_pkg::PhTrig : uer_pkg::PhSettle;
          timer_d = '0;
        end else if (timer_q >= timeout_q) begin
          done_c   = 1'b1;
          status_c = uer_pkg::StStuck;
        end else begin
          timer_d = timer_q + 16'd1;
        end
      end
      uer_pkg::PhSettle: begin
        timer_d = timer_q + 16'd1;
        if (timer_d >= 16'(settle_q)) begin
          phase_d = uer_pkg::PhTrig;
          timer_d = '0;
        end
      end
      uer_pkg::PhTrig: begin
        trig_c  = 1'b1;
        timer_d = timer_q + 16'd1;
        if (timer_d >= 16'(trig_w_q)) begin
          phase_d = uer_pkg::PhWaitRise;
          timer_d = '0;
        end
      end
      uer_pkg::PhWaitRise: begin
        if (echo_level_i) begin
          phase_d = uer_pkg::PhMeasure;
          timer_d = 16'd1;
        end else if (timer_q >= timeout_q) begin
          done_c   = 1'b1;
          status_c = uer_pkg::StNoEcho;
        end else begin
          timer_d = timer_q + 16'd1;
        end
      end
      uer_pkg::PhMeasure: begin
        if (echo_level_i) begin
          if (timer_q >= timeout_q) begin
            done_c   = 1'b1;
            status_c = uer_pkg::StStuck;
          end else begin
            timer_d = timer_q + 16'd1;
          end
        end else begin
          done_c = 1'b1;
          if (timer_q < min_pulse_q || timer_q > max_pulse_q) begin
            status_c = uer_pkg::StRange;
          end else begin
            ok_c         = 1'b1;
            hist_d[slot] = timer_q;
            slot_d       = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
            fill_d       = (fill_q < 2'd3) ? fill_q + 2'd1 : fill_q;
            if (fill_d == 2'd3) begin
              chosen_c = mid3(hist_d[0], hist_d[1], hist_d[2]);
            end
          end
        end
      end
      default: begin
        phase_d = uer_pkg::PhIdle;
        timer_d = '0;
        if (start_req_i) begin
          phase_d = uer_pkg::PhWaitLow;
        end else begin
          busy_c = 1'b0;
        end
      end
    endcase

    if (done_c) begin
      busy_c  = 1'b0;
      phase_d = uer_pkg::PhIdle;
      timer_d = '0;
    end
  end

  uer_dist #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dist (
    .pulse_i(chosen_c),
    .dist_o (dist_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= uer_pkg::PhIdle;
      timer_q <= '0;
      hist_q  <= '{default: '0};
      fill_q  <= '0;
      slot_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      hist_q  <= hist_d;
      fill_q  <= fill_d;
      slot_q  <= slot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, loaded with each accepted tick
  always_ff @(posedge clk_i) begin
    if (accept) begin
      trig_q   <= trig_c;
      busy_q   <= busy_c;
      done_q   <= done_c;
      status_q <= status_c;
      dist_q   <= ok_c ? dist_c : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign trig_level_o  = trig_q;
  assign busy_res_o    = busy_q;
  assign done_res_o    = done_q;
  assign status_o      = status_q;
  assign distance_q4_o = dist_q;

endmodule

FILE: verif/tb_ultrasonic_echo_ranger_core.sv
// Self-checking testbench for ultrasonic_echo_ranger_core with a tick-level predictor.
module tb_ultrasonic_echo_ranger_core;

  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic        trig;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [14:0] distance;
  } tick_result_t;

  // Tracks the sequencer and pulse history, queues the per-tick result.
  class ranger_scoreboard;
    logic [15:0]  timeout_us, min_pulse, max_pulse;
    logic [7:0]   trig_width, settle;
    logic [2:0]   phase;
    int unsigned  timer;
    logic [15:0]  history [3];
    int unsigned  fill, slot;
    tick_result_t result_q[$];
    int           mismatches, checked, medians;
    int           finished [4];

    function new();
      timeout_us = uer_pkg::TimeoutRst;
      min_pulse  = uer_pkg::MinPulseRst;
      max_pulse  = uer_pkg::MaxPulseRst;
      trig_width = uer_pkg::TrigWRst;
      settle     = uer_pkg::SettleRst;
      phase      = uer_pkg::PhIdle;
      timer      = 0;
      fill       = 0;
      slot       = 0;
      foreach (history[i]) history[i] = '0;
      foreach (finished[i]) finished[i] = 0;
      mismatches = 0;
      checked    = 0;
      medians    = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        uer_pkg::RegTimeout:  timeout_us = data;
        uer_pkg::RegMinPulse: min_pulse  = data;
        uer_pkg::RegMaxPulse: max_pulse  = data;
        uer_pkg::RegTrigW:    trig_width = data[7:0];
        uer_pkg::RegSettle:   settle     = data[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned mid_of_three(int unsigned a, int unsigned b, int unsigned c);
      int unsigned lo, hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (c < lo) return lo;
      if (c > hi) return hi;
      return c;
    endfunction

    function logic [1:0] grade_pulse(int unsigned pulse, output logic [14:0] distance);
      int unsigned s, chosen, d;
      distance = '0;
      if (pulse < min_pulse || pulse > max_pulse) return uer_pkg::StRange;
      s = (slot > 2) ? 0 : slot;
      history[s] = pulse[15:0];
      slot = (s + 1) % 3;
      if (fill < 3) fill++;
      if (fill < 3) begin
        chosen = pulse;
      end else begin
        chosen = mid_of_three(history[0], history[1], history[2]);
        medians++;
      end
      d = (chosen << uer_pkg::FractionBitsDefault) / uer_pkg::DistDivisor;
      if (d > uer_pkg::DistMax) d = uer_pkg::DistMax;
      distance = d[14:0];
      return uer_pkg::StOk;
    endfunction

    function void note_tick(bit echo, bit start);
      tick_result_t r;
      r = '{trig: 1'b0, busy: 1'b1, done: 1'b0, status: uer_pkg::StOk, distance: '0};
      case (phase)
        uer_pkg::PhWaitLow: begin
          if (!echo) begin
            phase = (settle == 0) ? uer_pkg::PhTrig : uer_pkg::PhSettle;
            timer = 0;
          end else if (timer >= timeout_us) begin
            r.done = 1'b1;
            r.status = uer_pkg::StStuck;
          end else begin
            timer++;
          end
        end
        uer_pkg::PhSettle: begin
          timer++;
          if (timer >= settle) begin
            phase = uer_pkg::PhTrig;
            timer = 0;
          end
        end
        uer_pkg::PhTrig: begin
          r.trig = 1'b1;
          timer++;
          if (timer >= trig_width) begin
            phase = uer_pkg::PhWaitRise;
            timer = 0;
          end
        end
        uer_pkg::PhWaitRise: begin
          if (echo) begin
            phase = uer_pkg::PhMeasure;
            timer = 1;
          end else if (timer >= timeout_us) begin
            r.done = 1'b1;
            r.status = uer_pkg::StNoEcho;
          end else begin
            timer++;
          end
        end
        uer_pkg::PhMeasure: begin
          if (echo) begin
            if (timer >= timeout_us) begin
              r.done = 1'b1;
              r.status = uer_pkg::StStuck;
            end else begin
              timer++;
            end
          end else begin
            r.done = 1'b1;
            r.status = grade_pulse(timer, r.distance);
          end
        end
        default: begin
          timer = 0;
          phase = start ? uer_pkg::PhWaitLow : uer_pkg::PhIdle;
          r.busy = start;
        end
      endcase
      if (r.done) begin
        r.busy = 1'b0;
        phase = uer_pkg::PhIdle;
        timer = 0;
        finished[r.status]++;
      end
      if (r.status != uer_pkg::StOk) r.distance = '0;
      result_q.push_back(r);
    endfunction

    function void check_result(tick_result_t act);
      tick_result_t exp;
      checked++;
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result transaction trig=%0b busy=%0b done=%0b st=%0d d=%0d",
                   act.trig, act.busy, act.done, act.status, act.distance);
        return;
      end
      exp = result_q.pop_front();
      if (exp.trig !== act.trig || exp.busy !== act.busy || exp.done !== act.done ||
          exp.status !== act.status || exp.distance !== act.distance) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d exp trig=%0b busy=%0b done=%0b st=%0d d=%0d, got %0b %0b %0b %0d %0d",
                   checked, exp.trig, exp.busy, exp.done, exp.status, exp.distance,
                   act.trig, act.busy, act.done, act.status, act.distance);
      end
    endfunction

    function int pending();
      return result_q.size();
    endfunction
  endclass

  logic        clk, rst_n;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid, in_ready, echo, start;
  logic        out_valid, out_ready;
  logic        trig_o, busy_o, done_o;
  logic [1:0]  status_o;
  logic [uer_pkg::DistWidth-1:0] dist_o;

  ranger_scoreboard sb;
  int          ticks_sent, burst_left, configs_used;
  int          cfg_timeout, cfg_min, cfg_max, cfg_trig, cfg_settle;
  bit          holdoff_req;
  int unsigned cycles;

  ultrasonic_echo_ranger_core uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .echo_level_i  (echo),
    .start_req_i   (start),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .trig_level_o  (trig_o),
    .busy_res_o    (busy_o),
    .done_res_o    (done_o),
    .status_o      (status_o),
    .distance_q4_o (dist_o)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("ERROR: timeout after %0d cycles, %0d results pending", cycles, sb.pending());
      $display("** ultrasonic_echo_ranger_core: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{trig: trig_o, busy: busy_o, done: done_o, status: status_o,
                        distance: dist_o});
  end

  // Receiver: randomly switching stall patterns, plus a long hold-off on request.
  initial begin
    int mode, left, holdoff_left, k;
    out_ready = 1'b0;
    left = 0;
    holdoff_left = 0;
    k = 0;
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        holdoff_left = 60;
        holdoff_req = 1'b0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(5, 40);
        end
        left--;
        k++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (k % 4) != 0;
        endcase
      end
    end
  end

  // Called at a falling edge; returns at a falling edge after the transaction.
  task automatic send_tick(bit e, bit s);
    int gap;
    in_valid <= 1'b1;
    echo     <= e;
    start    <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(e, s);
    ticks_sent++;
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic ping_tick(bit e, bit s);
    if ($urandom_range(0, 99) < 12) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    else send_tick(e, s);
  endtask

  task automatic stop_ticks();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending() > 0) @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_config(int t, int mn, int mx, int tw, int st);
    cfg_timeout = t;
    cfg_min     = mn;
    cfg_max     = mx;
    cfg_trig    = tw;
    cfg_settle  = st;
    configs_used++;
    cfg_write(uer_pkg::RegTimeout, t[15:0]);
    cfg_write(uer_pkg::RegMinPulse, mn[15:0]);
    cfg_write(uer_pkg::RegMaxPulse, mx[15:0]);
    // upper byte of the 8-bit registers is don't-care
    cfg_write(uer_pkg::RegTrigW, {8'($urandom_range(0, 255)), tw[7:0]});
    cfg_write(uer_pkg::RegSettle, {8'($urandom_range(0, 255)), st[7:0]});
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int pick_wait();
    if (cfg_timeout <= 40 && $urandom_range(0, 5) == 0) return cfg_timeout + 1;
    return $urandom_range(0, 4);
  endfunction

  function automatic int pick_pulse();
    int v, hi;
    case ($urandom_range(0, 9))
      0: v = cfg_min - 1;
      1: v = cfg_min;
      2: v = cfg_max;
      3: v = cfg_max + 1;
      4: v = cfg_timeout + $urandom_range(0, 1);
      default: begin
        if (cfg_min > cfg_max) begin
          v = $urandom_range(1, 20);
        end else begin
          hi = (cfg_max > cfg_min + 40) ? cfg_min + 40 : cfg_max;
          v = $urandom_range(cfg_min, hi);
        end
      end
    endcase
    if (v < 1 || v > 400) v = $urandom_range(1, 40);
    return v;
  endfunction

  // One ping as a sensor would answer it; noise and timeouts may break it up.
  task automatic measure_once();
    int n;
    n = $urandom_range(0, 2);
    repeat (n) ping_tick(1'($urandom_range(0, 1)), 1'b0);
    ping_tick(1'($urandom_range(0, 1)), 1'b1);
    n = pick_wait();
    repeat (n) ping_tick(1'b1, 1'($urandom_range(0, 1)));
    ping_tick(1'b0, 1'($urandom_range(0, 1)));
    n = cfg_settle + ((cfg_trig == 0) ? 1 : cfg_trig);
    repeat (n) ping_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    n = pick_wait();
    repeat (n) ping_tick(1'b0, 1'($urandom_range(0, 1)));
    n = pick_pulse();
    repeat (n) ping_tick(1'b1, 1'($urandom_range(0, 1)));
    ping_tick(1'b0, 1'($urandom_range(0, 1)));
  endtask

  // Walk the sequencer back to idle so registers can be rewritten.
  task automatic finish_ping();
    while (sb.phase != uer_pkg::PhIdle) send_tick(sb.phase == uer_pkg::PhWaitRise, 1'b0);
    stop_ticks();
    wait_drained();
  endtask

  task automatic run_phase(int budget, bit stress);
    int first, iter;
    first = ticks_sent;
    iter = 0;
    while (ticks_sent - first < budget || (stress && iter < 5)) begin
      measure_once();
      iter++;
      if (stress && iter == 2) holdoff_req = 1'b1;
      if (stress && iter == 5) begin
        stop_ticks();
        wait_drained();
      end
    end
    finish_ping();
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = uer_pkg::RegTimeout;
    cfg_data    = '0;
    in_valid    = 1'b0;
    echo        = 1'b0;
    start       = 1'b0;
    holdoff_req = 1'b0;
    cycles      = 0;
    ticks_sent  = 0;
    burst_left  = 0;
    configs_used = 1;
    cfg_timeout = uer_pkg::TimeoutRst;
    cfg_min     = uer_pkg::MinPulseRst;
    cfg_max     = uer_pkg::MaxPulseRst;
    cfg_trig    = uer_pkg::TrigWRst;
    cfg_settle  = uer_pkg::SettleRst;
    sb = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: idle, start, echo still high, settle, trigger, short pulse.
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    repeat (10) send_tick(1'($urandom_range(0, 1)), 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    finish_ping();

    set_config(30, 3, 20, 2, 1);
    run_phase(100, 1'b1);
    // zero timeout, zero width, zero settle, empty window
    set_config(0, 0, 0, 0, 0);
    run_phase(30, 1'b0);
    // crossed limits
    set_config(12, 10, 4, 1, 3);
    run_phase(40, 1'b0);
    set_config(65535, 0, 65535, 30, 20);
    run_phase(40, 1'b0);
    repeat (4) begin
      set_config($urandom_range(1, 40), $urandom_range(0, 8), $urandom_range(4, 30),
                 $urandom_range(0, 4), $urandom_range(0, 4));
      run_phase(15, 1'b0);
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Covered %0d ticks over %0d register settings, %0d results checked.",
             ticks_sent, configs_used, sb.checked);
    $display("Pings ended ok=%0d no-echo=%0d stuck=%0d out-of-range=%0d, median used %0d times.",
             sb.finished[uer_pkg::StOk], sb.finished[uer_pkg::StNoEcho],
             sb.finished[uer_pkg::StStuck], sb.finished[uer_pkg::StRange], sb.medians);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** ultrasonic_echo_ranger_core: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("** ultrasonic_echo_ranger_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/uer_pkg.sv
hdl/uer_dist.sv
hdl/ultrasonic_echo_ranger_core.sv
verif/tb_ultrasonic_echo_ranger_core.sv
